/* hw/rtl/reader_writer_lock_manager_assert.svh */
// Assertion macros for the reader-writer lock manager.
`ifndef READER_WRITER_LOCK_MANAGER_ASSERT_SVH
`define READER_WRITER_LOCK_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RWLM_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rwlm: assertion failed");

// Next-cycle implication.
`define RWLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rwlm: assertion failed");

`endif

/* hw/rtl/rwlm_pkg.sv */
// Types and codes used by the lock manager.
package rwlm_pkg;

    typedef enum logic [2:0] {
        A_SHARED = 3'd0,
        A_EXCL   = 3'd1,
        A_TRY    = 3'd2,
        A_UNLOCK = 3'd3,
        A_QUERY  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_GRANTED    = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_REFUSED    = 4'd2,
        ST_RELEASED   = 4'd3,
        ST_WOKEN      = 4'd4,
        ST_FULL       = 4'd5,
        ST_UNLOCK_ERR = 4'd6,
        ST_OVERFLOW   = 4'd7,
        ST_REPORT     = 4'd8
    } t_status;

endpackage

/* hw/rtl/rwlm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rwlm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/reader_writer_lock_manager.sv */
// Reader-writer lock manager: hold count, exclusive owner and FIFO of waiters.
//
//  channel  direction  handshake                  words
//  request  in         i_in_valid / o_in_ready    i_action, i_thread_id
//  result   out        o_out_valid / i_out_ready  o_status .. o_last
//
// A request is taken in S_IDLE and run in S_EXEC, which waits while the result is stalled.
// An unlock that wakes waiters goes through S_REL, then S_NEXT and S_WAKE for each one; each
// wake waits on one read of the wait-queue RAM port to look ahead at the next waiter.
// Reset is synchronous and clears count, owner and queue pointers; queue RAM is not cleared.
// A stalled result holds the sequencer; o_in_ready is high only when it is idle.
module reader_writer_lock_manager
    import rwlm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int COUNT_BITS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_action,
    input  logic [ID_BITS-1:0]               i_thread_id,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [3:0]                       o_status,
    output logic [ID_BITS-1:0]               o_subject_id,
    output logic                             o_grant_exclusive,
    output logic                             o_exclusive_locked,
    output logic                             o_caller_holds_exclusive,
    output logic [COUNT_BITS-1:0]            o_holders,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_waiting,
    output logic                             o_last
);

    localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int WAIT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_BITS  = ID_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [WAIT_BITS-1:0]  WAIT_FULL = WAIT_BITS'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REL,
        S_NEXT,
        S_WAKE
    } t_state;

    t_state                r_state, n_state;
    logic [2:0]            r_action;
    logic [ID_BITS-1:0]    r_tid;
    logic [COUNT_BITS-1:0] r_hold, n_hold;
    logic                  r_owner_valid, n_owner_valid;
    logic [ID_BITS-1:0]    r_owner_id, n_owner_id;
    logic [PTR_BITS-1:0]   r_head, n_head;
    logic [PTR_BITS-1:0]   r_tail, n_tail;
    logic [WAIT_BITS-1:0]  r_count, n_count;
    logic [ENT_BITS-1:0]   r_cur, n_cur;
    logic                  r_fin_ex, n_fin_ex;
    logic                  r_fin_chx, n_fin_chx;

    logic                  r_ovalid, n_ovalid;
    t_status               r_status, n_status;
    logic [ID_BITS-1:0]    r_subj, n_subj;
    logic                  r_gx, n_gx;
    logic                  r_exl, n_exl;
    logic                  r_chx, n_chx;
    logic [COUNT_BITS-1:0] r_oholders, n_oholders;
    logic [WAIT_BITS-1:0]  r_owaiting, n_owaiting;
    logic                  r_last, n_last;

    logic                  ram_we;
    logic [ENT_BITS-1:0]   ram_wdata;
    logic [PTR_BITS-1:0]   ram_raddr;
    logic [ENT_BITS-1:0]   ram_rdata;

    logic                  out_free;
    logic                  owns;
    logic                  emit;
    logic                  ent_ex;
    logic [ID_BITS-1:0]    ent_id;
    logic                  wake_more;
    logic [COUNT_BITS-1:0] hold_inc;
    logic [COUNT_BITS-1:0] hold_dec;
    logic [WAIT_BITS-1:0]  count_dec;

    function automatic logic [PTR_BITS-1:0] next_index(input logic [PTR_BITS-1:0] idx);
        return (idx == PTR_LAST) ? '0 : idx + 1'b1;
    endfunction

    rwlm_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_ovalid || i_out_ready;
    assign owns      = r_owner_valid && (r_owner_id == r_tid);
    assign hold_inc  = r_hold + 1'b1;
    assign hold_dec  = r_hold - 1'b1;
    assign count_dec = r_count - 1'b1;
    assign ent_ex    = ram_rdata[ID_BITS];
    assign ent_id    = ram_rdata[ID_BITS-1:0];
    assign wake_more = !r_cur[ID_BITS] && (count_dec != '0) && !ent_ex
                       && (hold_inc != COUNT_MAX);

    always_comb begin
        n_state       = r_state;
        n_hold        = r_hold;
        n_owner_valid = r_owner_valid;
        n_owner_id    = r_owner_id;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_cur         = r_cur;
        n_fin_ex      = r_fin_ex;
        n_fin_chx     = r_fin_chx;
        n_ovalid      = r_ovalid && !i_out_ready;
        n_status      = r_status;
        n_subj        = r_subj;
        n_gx          = r_gx;
        n_exl         = r_exl;
        n_chx         = r_chx;
        n_oholders    = r_oholders;
        n_owaiting    = r_owaiting;
        n_last        = r_last;
        ram_we        = 1'b0;
        ram_wdata     = {1'b0, r_tid};
        ram_raddr     = r_head;
        emit          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_action == A_UNLOCK && r_hold == COUNT_BITS'(1) && r_count != '0) begin
                    n_state = S_REL;
                end else if (out_free) begin
                    emit     = 1'b1;
                    n_gx     = 1'b0;
                    n_status = ST_REPORT;
                    case (r_action) inside
                        A_SHARED: begin
                            if (r_hold != '0 && r_owner_valid && r_owner_id != r_tid) begin
                                if (r_count == WAIT_FULL) begin
                                    n_status = ST_FULL;
                                end else begin
                                    ram_we   = 1'b1;
                                    n_tail   = next_index(r_tail);
                                    n_count  = r_count + 1'b1;
                                    n_status = ST_QUEUED;
                                end
                            end else if (r_hold == COUNT_MAX) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_hold   = hold_inc;
                                n_status = ST_GRANTED;
                            end
                        end
                        A_EXCL, A_TRY: begin
                            if (r_hold != '0 && !owns) begin
                                if (r_action == A_TRY) begin
                                    n_status = ST_REFUSED;
                                end else if (r_count == WAIT_FULL) begin
                                    n_status = ST_FULL;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {1'b1, r_tid};
                                    n_tail    = next_index(r_tail);
                                    n_count   = r_count + 1'b1;
                                    n_status  = ST_QUEUED;
                                end
                            end else if (r_hold == COUNT_MAX) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_hold        = hold_inc;
                                n_owner_valid = 1'b1;
                                n_owner_id    = r_tid;
                                n_gx          = 1'b1;
                                n_status      = ST_GRANTED;
                            end
                        end
                        A_UNLOCK: begin
                            if (r_hold == '0) begin
                                n_status = ST_UNLOCK_ERR;
                            end else begin
                                n_hold = hold_dec;
                                if (hold_dec == '0) begin
                                    n_owner_valid = 1'b0;
                                end
                                n_status = ST_RELEASED;
                            end
                        end
                        default: begin
                            n_status = ST_REPORT;
                        end
                    endcase
                    n_subj     = r_tid;
                    n_oholders = n_hold;
                    n_owaiting = n_count;
                    n_exl      = n_owner_valid;
                    n_chx      = n_owner_valid && (n_owner_id == r_tid);
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_REL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_hold     = '0;
                    n_cur      = ram_rdata;
                    n_fin_ex   = ent_ex;
                    n_fin_chx  = ent_ex && (ent_id == r_tid);
                    n_status   = ST_RELEASED;
                    n_subj     = r_tid;
                    n_gx       = 1'b0;
                    n_oholders = '0;
                    n_owaiting = r_count;
                    n_exl      = ent_ex;
                    n_chx      = ent_ex && (ent_id == r_tid);
                    n_last     = 1'b0;
                    n_state    = S_NEXT;
                end
            end
            S_NEXT: begin
                ram_raddr = next_index(r_head);
                n_state   = S_WAKE;
            end
            S_WAKE: begin
                ram_raddr = next_index(r_head);
                if (out_free) begin
                    emit          = 1'b1;
                    n_head        = next_index(r_head);
                    n_count       = count_dec;
                    n_hold        = hold_inc;
                    n_owner_valid = r_cur[ID_BITS];
                    n_owner_id    = r_cur[ID_BITS] ? r_cur[ID_BITS-1:0] : '0;
                    n_status      = ST_WOKEN;
                    n_subj        = r_cur[ID_BITS-1:0];
                    n_gx          = r_cur[ID_BITS];
                    n_oholders    = hold_inc;
                    n_owaiting    = count_dec;
                    n_exl         = r_fin_ex;
                    n_chx         = r_fin_chx;
                    n_last        = !wake_more;
                    if (wake_more) begin
                        n_cur   = ram_rdata;
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_hold        <= '0;
            r_owner_valid <= 1'b0;
            r_owner_id    <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_hold        <= n_hold;
            r_owner_valid <= n_owner_valid;
            r_owner_id    <= n_owner_id;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_ovalid      <= n_ovalid;
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_action <= i_action;
            r_tid    <= i_thread_id;
        end
        r_cur      <= n_cur;
        r_fin_ex   <= n_fin_ex;
        r_fin_chx  <= n_fin_chx;
        r_status   <= n_status;
        r_subj     <= n_subj;
        r_gx       <= n_gx;
        r_exl      <= n_exl;
        r_chx      <= n_chx;
        r_oholders <= n_oholders;
        r_owaiting <= n_owaiting;
        r_last     <= n_last;
    end

    assign o_in_ready               = (r_state == S_IDLE);
    assign o_out_valid              = r_ovalid;
    assign o_status                 = r_status;
    assign o_subject_id             = r_subj;
    assign o_grant_exclusive        = r_gx;
    assign o_exclusive_locked       = r_exl;
    assign o_caller_holds_exclusive = r_chx;
    assign o_holders                = r_oholders;
    assign o_waiting                = r_owaiting;
    assign o_last                   = r_last;

`include "reader_writer_lock_manager_assert.svh"

    `RWLM_ASSERT(a_count_bound, 1'b1, r_count <= WAIT_FULL)
    `RWLM_ASSERT(a_empty_ptrs, r_count == '0, r_head == r_tail)
    `RWLM_ASSERT(a_run_busy, o_out_valid && i_out_ready && !o_last, !o_in_ready)
    `RWLM_ASSERT(a_excl_wake_last, o_out_valid && o_status == ST_WOKEN && o_grant_exclusive, o_last)
    `RWLM_ASSERT_NEXT(a_take_exec, o_in_ready && i_in_valid, r_state == S_EXEC)

endmodule
